### hw/rtl/gerd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gerd_pkg
// shared types and constants for the gamepad edge and radial deadzone core
// ----------------------------------------------------------------------------
package gerd_pkg;

  localparam int unsigned ButtonBits = 16;
  localparam logic [15:0] ButtonMask = 16'((64'd1 << ButtonBits) - 64'd1);

  localparam logic [15:0] DeadzoneReset = 16'd3277;

  localparam int unsigned CfgIdxW = 8;
  localparam logic [CfgIdxW-1:0] RegDeadzone = 8'd0;
  localparam logic [CfgIdxW-1:0] RegInvertY  = 8'd1;

  typedef struct packed {
    logic               connected;
    logic [15:0]        buttons;
    logic signed [15:0] left_x;
    logic signed [15:0] left_y;
    logic signed [15:0] right_x;
    logic signed [15:0] right_y;
  } gerd_in_t;

  typedef struct packed {
    logic [15:0]        held;
    logic [15:0]        pressed;
    logic [15:0]        released;
    logic signed [15:0] left_out_x;
    logic signed [15:0] left_out_y;
    logic signed [15:0] right_out_x;
    logic signed [15:0] right_out_y;
  } gerd_out_t;

  typedef struct packed {
    logic [15:0]        held;
    logic [15:0]        pressed;
    logic [15:0]        released;
    logic signed [15:0] lx;
    logic signed [15:0] ly;
    logic signed [15:0] rx;
    logic signed [15:0] ry;
  } gerd_item_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
  } gerd_stick_res_t;

endpackage

### hw/rtl/gerd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gerd_front
// accepts a poll, finds button edges, applies y inversion, queues the item
// ----------------------------------------------------------------------------
module gerd_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  gerd_pkg::gerd_in_t  in_data_i,
  input  logic                invert_y_i,
  input  logic                full_i,
  output logic                push_o,
  output gerd_pkg::gerd_item_t push_data_o
);
  import gerd_pkg::*;

  logic [15:0] prev_q, prev_d;
  logic [15:0] held;
  logic        conn;

  function automatic logic signed [15:0] neg_sat(input logic signed [15:0] v);
    return (v == -16'sd32768) ? 16'sd32767 : -v;
  endfunction

  assign in_stall_o = full_i;
  assign push_o     = in_valid_i & ~full_i;
  assign conn       = in_data_i.connected;
  assign held       = conn ? (in_data_i.buttons & ButtonMask) : 16'd0;

  always_comb begin
    push_data_o.held     = held;
    push_data_o.pressed  = held & ~prev_q;
    push_data_o.released = conn ? (prev_q & ~held) : 16'd0;
    push_data_o.lx       = conn ? in_data_i.left_x : 16'sd0;
    push_data_o.rx       = conn ? in_data_i.right_x : 16'sd0;
    if (!conn) begin
      push_data_o.ly = 16'sd0;
      push_data_o.ry = 16'sd0;
    end else if (invert_y_i) begin
      push_data_o.ly = neg_sat(in_data_i.left_y);
      push_data_o.ry = neg_sat(in_data_i.right_y);
    end else begin
      push_data_o.ly = in_data_i.left_y;
      push_data_o.ry = in_data_i.right_y;
    end
    prev_d = push_o ? held : prev_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= 16'd0;
    end else begin
      prev_q <= prev_d;
    end
  end

endmodule

### hw/rtl/gerd_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gerd_fifo
// two-entry queue between front and back
// ----------------------------------------------------------------------------
module gerd_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  gerd_pkg::gerd_item_t push_data_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output logic                 empty_o,
  output gerd_pkg::gerd_item_t pop_data_o
);
  import gerd_pkg::*;

  gerd_item_t  mem_q [2];
  logic        wr_q, wr_d, rd_q, rd_d;
  logic [1:0]  cnt_q, cnt_d;

  assign full_o     = (cnt_q == 2'd2);
  assign empty_o    = (cnt_q == 2'd0);
  assign pop_data_o = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? ~wr_q : wr_q;
    rd_d  = pop_i ? ~rd_q : rd_q;
    cnt_d = cnt_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

### hw/rtl/gerd_stick.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gerd_stick
// iterative radial deadzone for one stick: square root, scale divide, axis divides
// ----------------------------------------------------------------------------
module gerd_stick (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic signed [15:0]        x_i,
  input  logic signed [15:0]        y_i,
  input  logic [15:0]               deadzone_i,
  output logic                      busy_o,
  output gerd_pkg::gerd_stick_res_t res_o
);
  import gerd_pkg::*;

  localparam logic [2:0] SIdle  = 3'd0;
  localparam logic [2:0] SMul   = 3'd1;
  localparam logic [2:0] SSum   = 3'd2;
  localparam logic [2:0] SSqrt  = 3'd3;
  localparam logic [2:0] SPrep  = 3'd4;
  localparam logic [2:0] STdiv  = 3'd5;
  localparam logic [2:0] SScale = 3'd6;
  localparam logic [2:0] SAdiv  = 3'd7;

  logic [2:0]         st_q, st_d;
  logic [4:0]         cnt_q, cnt_d;
  logic signed [15:0] x_q, x_d, y_q, y_d;
  logic [30:0]        sx_q, sx_d, sy_q, sy_d;
  logic [61:0]        dzsq_q, dzsq_d;
  logic [47:0]        v_q, v_d;
  logic [25:0]        srem_q, srem_d;
  logic [23:0]        root_q, root_d;
  logic [30:0]        drem_q, drem_d;
  logic [16:0]        t_q, t_d;
  logic [23:0]        remx_q, remx_d, remy_q, remy_d;
  logic [16:0]        lowx_q, lowx_d, lowy_q, lowy_d;
  logic [16:0]        qx_q, qx_d, qy_q, qy_d;
  gerd_stick_res_t    res_q, res_d;

  logic [30:0] dz, den;
  logic [31:0] ssum;
  logic [27:0] rem2, trial;
  logic signed [33:0] n;
  logic [31:0] d2;
  logic [16:0] ax, ay;
  logic [40:0] numx, numy;
  logic [24:0] rx2, ry2;

  function automatic logic signed [15:0] sat(input logic neg, input logic [16:0] q);
    logic [16:0] m;
    if (neg) begin
      m = (q > 17'd32768) ? 17'd32768 : q;
      return 16'(-m);
    end
    m = (q > 17'd32767) ? 17'd32767 : q;
    return 16'(m);
  endfunction

  assign busy_o = (st_q != SIdle);
  assign res_o  = res_q;

  always_comb begin
    dz    = {deadzone_i, 15'd0} - 31'(deadzone_i);
    den   = {15'd32767, 16'd0} - dz;
    ssum  = 32'(sx_q) + 32'(sy_q);
    rem2  = {srem_q, v_q[47:46]};
    trial = {2'b00, root_q[23:0], 2'b01} >> 0;
    n     = 34'sd0 + $signed({2'b00, root_q, 8'd0}) - $signed({3'b000, dz});
    d2    = {1'b0, drem_q} << 1;
    ax    = x_q[15] ? 17'(-{x_q[15], x_q}) : {1'b0, x_q};
    ay    = y_q[15] ? 17'(-{y_q[15], y_q}) : {1'b0, y_q};
    numx  = {34'(ax * t_q), 7'd0} + 41'(root_q >> 1);
    numy  = {34'(ay * t_q), 7'd0} + 41'(root_q >> 1);
    rx2   = {remx_q, lowx_q[16]};
    ry2   = {remy_q, lowy_q[16]};

    st_d = st_q; cnt_d = cnt_q; x_d = x_q; y_d = y_q;
    sx_d = sx_q; sy_d = sy_q; dzsq_d = dzsq_q; v_d = v_q;
    srem_d = srem_q; root_d = root_q; drem_d = drem_q; t_d = t_q;
    remx_d = remx_q; remy_d = remy_q; lowx_d = lowx_q; lowy_d = lowy_q;
    qx_d = qx_q; qy_d = qy_q; res_d = res_q;

    unique case (st_q)
      SIdle: begin
        if (start_i) begin
          x_d  = x_i;
          y_d  = y_i;
          st_d = SMul;
        end
      end
      SMul: begin
        sx_d   = 31'(x_q * x_q);
        sy_d   = 31'(y_q * y_q);
        dzsq_d = 62'(dz * dz);
        st_d   = SSum;
      end
      SSum: begin
        if ({ssum, 32'd0} < {2'b00, dzsq_q}) begin
          res_d = '0;
          st_d  = SIdle;
        end else begin
          v_d    = {ssum, 16'd0};
          srem_d = '0;
          root_d = '0;
          cnt_d  = 5'd23;
          st_d   = SSqrt;
        end
      end
      SSqrt: begin
        if (rem2 >= trial) begin
          srem_d = 26'(rem2 - trial);
          root_d = {root_q[22:0], 1'b1};
        end else begin
          srem_d = rem2[25:0];
          root_d = {root_q[22:0], 1'b0};
        end
        v_d   = {v_q[45:0], 2'b00};
        cnt_d = cnt_q - 5'd1;
        if (cnt_q == 5'd0) begin
          st_d = SPrep;
        end
      end
      SPrep: begin
        if (root_q == 24'd0 || n <= 34'sd0) begin
          res_d = '0;
          st_d  = SIdle;
        end else if (n >= $signed({3'b000, den})) begin
          t_d  = 17'd65536;
          st_d = SScale;
        end else begin
          drem_d = n[30:0];
          t_d    = '0;
          cnt_d  = 5'd15;
          st_d   = STdiv;
        end
      end
      STdiv: begin
        if (d2 >= {1'b0, den}) begin
          drem_d = 31'(d2 - {1'b0, den});
          t_d    = {t_q[15:0], 1'b1};
        end else begin
          drem_d = d2[30:0];
          t_d    = {t_q[15:0], 1'b0};
        end
        cnt_d = cnt_q - 5'd1;
        if (cnt_q == 5'd0) begin
          st_d = SScale;
        end
      end
      SScale: begin
        remx_d = numx[40:17];
        lowx_d = numx[16:0];
        remy_d = numy[40:17];
        lowy_d = numy[16:0];
        qx_d   = '0;
        qy_d   = '0;
        cnt_d  = 5'd16;
        st_d   = SAdiv;
      end
      SAdiv: begin
        if (rx2 >= {1'b0, root_q}) begin
          remx_d = 24'(rx2 - {1'b0, root_q});
          qx_d   = {qx_q[15:0], 1'b1};
        end else begin
          remx_d = rx2[23:0];
          qx_d   = {qx_q[15:0], 1'b0};
        end
        if (ry2 >= {1'b0, root_q}) begin
          remy_d = 24'(ry2 - {1'b0, root_q});
          qy_d   = {qy_q[15:0], 1'b1};
        end else begin
          remy_d = ry2[23:0];
          qy_d   = {qy_q[15:0], 1'b0};
        end
        lowx_d = {lowx_q[15:0], 1'b0};
        lowy_d = {lowy_q[15:0], 1'b0};
        cnt_d  = cnt_q - 5'd1;
        if (cnt_q == 5'd0) begin
          res_d.x = sat(x_q[15], qx_d);
          res_d.y = sat(y_q[15], qy_d);
          st_d    = SIdle;
        end
      end
      default: st_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d; x_q <= x_d; y_q <= y_d;
    sx_q <= sx_d; sy_q <= sy_d; dzsq_q <= dzsq_d; v_q <= v_d;
    srem_q <= srem_d; root_q <= root_d; drem_q <= drem_d; t_q <= t_d;
    remx_q <= remx_d; remy_q <= remy_d; lowx_q <= lowx_d; lowy_q <= lowy_d;
    qx_q <= qx_d; qy_q <= qy_d; res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle;
    end else begin
      st_q <= st_d;
    end
  end

endmodule

### hw/rtl/gerd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gerd_back
// takes queued items, runs both stick units, holds the result beat
// ----------------------------------------------------------------------------
module gerd_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 empty_i,
  input  gerd_pkg::gerd_item_t pop_data_i,
  output logic                 pop_o,
  input  logic [15:0]          deadzone_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output gerd_pkg::gerd_out_t  out_data_o
);
  import gerd_pkg::*;

  localparam logic StIdle = 1'b0;
  localparam logic StRun  = 1'b1;

  logic            st_q, st_d;
  logic            vld_q, vld_d;
  gerd_item_t      item_q, item_d;
  gerd_out_t       out_q, out_d;
  logic            busy_l, busy_r, load;
  gerd_stick_res_t res_l, res_r;

  assign pop_o       = (st_q == StIdle) & ~empty_i;
  assign load        = (st_q == StRun) & ~busy_l & ~busy_r & (~vld_q | ~out_stall_i);
  assign out_valid_o = vld_q;
  assign out_data_o  = out_q;

  gerd_stick u_left (
    .clk_i, .rst_ni, .start_i(pop_o), .x_i(pop_data_i.lx), .y_i(pop_data_i.ly),
    .deadzone_i, .busy_o(busy_l), .res_o(res_l)
  );

  gerd_stick u_right (
    .clk_i, .rst_ni, .start_i(pop_o), .x_i(pop_data_i.rx), .y_i(pop_data_i.ry),
    .deadzone_i, .busy_o(busy_r), .res_o(res_r)
  );

  always_comb begin
    st_d   = st_q;
    vld_d  = vld_q;
    item_d = item_q;
    out_d  = out_q;
    if (pop_o) begin
      item_d = pop_data_i;
      st_d   = StRun;
    end
    if (load) begin
      out_d.held        = item_q.held;
      out_d.pressed     = item_q.pressed;
      out_d.released    = item_q.released;
      out_d.left_out_x  = res_l.x;
      out_d.left_out_y  = res_l.y;
      out_d.right_out_x = res_r.x;
      out_d.right_out_y = res_r.y;
      vld_d = 1'b1;
      st_d  = StIdle;
    end else if (!out_stall_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    out_q  <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= StIdle;
      vld_q <= 1'b0;
    end else begin
      st_q  <= st_d;
      vld_q <= vld_d;
    end
  end

endmodule

### hw/rtl/gamepad_edge_and_radial_deadzone_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gamepad_edge_and_radial_deadzone_core
// button edge masks and scaled radial deadzone on two sticks per poll
// ----------------------------------------------------------------------------
// a poll passes the front, the queue, both stick units (which finish early inside the
// deadzone) and the result register; the sticks take a new poll only after the last
// result is loaded, at a rate set by the bit-serial square root and the two restoring
// divides per unit (units run side by side); a two-beat queue takes polls meanwhile
// reset: asynchronous active low; deadzone 3277, no y inversion, previous buttons clear
module gamepad_edge_and_radial_deadzone_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  gerd_pkg::gerd_in_t                   in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output gerd_pkg::gerd_out_t                  out_data_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [gerd_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [15:0]                          cfg_data_i
);
  import gerd_pkg::*;

  logic [15:0] deadzone_q, deadzone_d;
  logic        invert_q, invert_d;
  logic        q_push, q_full;
  gerd_item_t  push_data, pop_data;
  logic        pop, empty;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    deadzone_d = deadzone_q;
    invert_d   = invert_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegDeadzone: deadzone_d = cfg_data_i;
        RegInvertY:  invert_d   = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deadzone_q <= DeadzoneReset;
      invert_q   <= 1'b0;
    end else begin
      deadzone_q <= deadzone_d;
      invert_q   <= invert_d;
    end
  end

  gerd_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .invert_y_i(invert_q), .full_i(q_full), .push_o(q_push), .push_data_o(push_data)
  );

  gerd_fifo u_fifo (
    .clk_i, .rst_ni, .push_i(q_push), .push_data_i(push_data), .full_o(q_full),
    .pop_i(pop), .empty_o(empty), .pop_data_o(pop_data)
  );

  gerd_back u_back (
    .clk_i, .rst_ni, .empty_i(empty), .pop_data_i(pop_data), .pop_o(pop),
    .deadzone_i(deadzone_q), .out_valid_o, .out_stall_i, .out_data_o
  );

endmodule

### hw/rtl/gerd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gerd_checker
// port-level checks on the core, attached by bind
// ----------------------------------------------------------------------------
module gerd_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input gerd_pkg::gerd_in_t           in_data_i,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input gerd_pkg::gerd_out_t          out_data_o
);
  import gerd_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result beat dropped or changed");

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_data_i))
    else $error("stalled poll beat dropped or changed");

  a_edges_disjoint: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.pressed & out_data_o.released) == 16'd0)
    else $error("button both pressed and released");

  a_edges_vs_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((out_data_o.pressed & ~out_data_o.held) == 16'd0)
                 && ((out_data_o.released & out_data_o.held) == 16'd0))
    else $error("edge masks disagree with held word");

  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(!rst_ni) |-> !out_valid_o)
    else $error("result beat straight out of reset");

endmodule

bind gamepad_edge_and_radial_deadzone_core gerd_checker u_gerd_checker (.*);
